/* rtl/lcf_pkg.sv */
// Shared types and constants of the linear calibration fit block.
`timescale 1ns / 1ps
package lcf_pkg;

    localparam int CNT_W   = 8;   // point count, up to 255 points
    localparam int SUM_W   = 24;  // sum of up to 255 16-bit values
    localparam int SQ_W    = 40;  // sum of up to 255 products of 16-bit values
    localparam int MAG_W   = 48;  // spread and slope numerators
    localparam int WIDE_W  = 64;  // full products of the sums
    localparam int DIVD_W  = 72;  // shifted dividends
    localparam int MPLR_W  = 24;  // multiplier operand width of the serial multiplier
    localparam int JOBQ_DEPTH = 2;

    localparam logic [1:0] FIT_OK       = 2'd0;
    localparam logic [1:0] FIT_NO_SPREAD = 2'd1;
    localparam logic [1:0] FIT_NO_SLOPE  = 2'd2;
    localparam logic [1:0] FIT_TOO_MANY  = 2'd3;

    typedef struct packed {
        logic [15:0] set_point;
        logic [15:0] measured;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic [1:0]         fit_status;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [SQ_W-1:0]  sxy;
        logic [SQ_W-1:0]  sxx;
        logic             ovf;
    } job_t;

endpackage

/* rtl/linear_calibration_fit_core.sv */
// Top level of the least-squares linear calibration fit.
`timescale 1ns / 1ps
// Sample beats (set point, measured, last) are accepted one per clock while full
// is low; each beat is folded into the running count and sums in the same cycle.
// A beat marked last closes the set and hands its sums to a two-entry job queue,
// so accumulation of the next calibration can go on while the fit is worked out.
// The fit itself runs in a shared serial unit: six shift-add products, then two
// restoring divisions with a rounding step after each; an error status skips the
// divisions, since the status is only known once all six products are done.
// full rises only when two closed sets are still waiting in the queue.
// The result beat stays on result while empty is low until it is popped.
module linear_calibration_fit_core #(
    parameter int MAX_POINTS = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  lcf_pkg::sample_t sample,
    output logic             empty,
    input  logic             pop,
    output lcf_pkg::result_t result
);

    logic          job_push, job_full, job_valid, job_pop;
    lcf_pkg::job_t job_in, job_out;

    lcf_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .job_push (job_push),
        .job_full (job_full),
        .job      (job_in)
    );

    lcf_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .full   (job_full),
        .rd     (job_pop),
        .valid  (job_valid),
        .rd_job (job_out)
    );

    lcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* rtl/lcf_front.sv */
// Front part: accumulates sample pairs and hands finished sums to the job queue.
`timescale 1ns / 1ps
module lcf_front #(
    parameter int MAX_POINTS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lcf_pkg::sample_t sample,
    output logic            job_push,
    input  logic            job_full,
    output lcf_pkg::job_t   job
);

    logic [lcf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [lcf_pkg::SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [lcf_pkg::SQ_W-1:0]  sxy_reg, sxy_next, sxx_reg, sxx_next;
    logic                      ovf_reg, ovf_next;
    logic                      accept;
    logic [31:0]               pxy, pxx;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign pxy    = sample.set_point * sample.measured;
    assign pxx    = sample.set_point * sample.set_point;

    always_comb
    begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxy_next = sxy_reg;
        sxx_next = sxx_reg;
        ovf_next = ovf_reg;
        if (cnt_reg >= lcf_pkg::CNT_W'(MAX_POINTS))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + lcf_pkg::SUM_W'(sample.set_point);
            sy_next  = sy_reg + lcf_pkg::SUM_W'(sample.measured);
            sxy_next = sxy_reg + lcf_pkg::SQ_W'(pxy);
            sxx_next = sxx_reg + lcf_pkg::SQ_W'(pxx);
        end
    end

    assign job_push = accept && sample.last;
    assign job = '{n: cnt_next, sx: sx_next, sy: sy_next, sxy: sxy_next, sxx: sxx_next,
                   ovf: ovf_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (sample.last)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxy_reg <= '0;
                sxx_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sx_reg  <= sx_next;
                sy_reg  <= sy_next;
                sxy_reg <= sxy_next;
                sxx_reg <= sxx_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

/* rtl/lcf_job_queue.sv */
// Short queue of finished sum sets between the front and the back part.
`timescale 1ns / 1ps
module lcf_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  lcf_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd,
    output logic          valid,
    output lcf_pkg::job_t rd_job
);

    localparam int PTR_W = $clog2(lcf_pkg::JOBQ_DEPTH);

    lcf_pkg::job_t      entry_reg [lcf_pkg::JOBQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_wr, do_rd;

    assign full   = (count_reg == (PTR_W+1)'(lcf_pkg::JOBQ_DEPTH));
    assign valid  = (count_reg != '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && valid;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/lcf_back.sv */
// Back part: serial multiplier and restoring divider that turn sums into the fit.
`timescale 1ns / 1ps
module lcf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_pop,
    input  lcf_pkg::job_t    job,
    output logic             empty,
    input  logic             pop,
    output lcf_pkg::result_t result
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_RND  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [2:0] OP_N_SXX   = 3'd0;
    localparam logic [2:0] OP_SX_SX   = 3'd1;
    localparam logic [2:0] OP_N_SXY   = 3'd2;
    localparam logic [2:0] OP_SX_SY   = 3'd3;
    localparam logic [2:0] OP_SX_SXY  = 3'd4;
    localparam logic [2:0] OP_SY_SXX  = 3'd5;

    localparam int W  = lcf_pkg::WIDE_W;
    localparam int MW = lcf_pkg::MAG_W;
    localparam int DW = lcf_pkg::DIVD_W;
    localparam int BW = lcf_pkg::MPLR_W;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [6:0]         cnt_reg, cnt_next;
    lcf_pkg::job_t      job_reg, job_next;
    logic [W-1:0]       mcand_reg, mcand_next, acc_reg, acc_next, tmp_reg, tmp_next;
    logic [BW-1:0]      mplier_reg, mplier_next;
    logic [MW-1:0]      den_reg, den_next, num_mag_reg, num_mag_next;
    logic               num_neg_reg, num_neg_next, diff_neg_reg, diff_neg_next;
    logic [W-1:0]       diff_reg, diff_next;
    logic [DW-1:0]      dq_reg, dq_next;
    logic [MW:0]        rem_reg, rem_next;
    logic               div_sel_reg, div_sel_next;
    logic [31:0]        gain_reg, gain_next;
    lcf_pkg::result_t   result_reg, result_next;

    logic [2:0]         ld_op;
    lcf_pkg::job_t      ld_job;
    logic [W-1:0]       ld_a;
    logic [BW-1:0]      ld_b;
    logic [W-1:0]       acc_sum, sub, mag;
    logic               lt;
    logic [MW:0]        shifted;
    logic               ge;
    logic               rnd, neg;
    logic [DW:0]        q, lim, v;
    logic [31:0]        val;

    // Operand selection for the product that is about to start.
    assign ld_op  = (state_reg == ST_IDLE) ? OP_N_SXX : op_reg + 3'd1;
    assign ld_job = (state_reg == ST_IDLE) ? job : job_reg;

    always_comb
    begin
        case (ld_op)
            OP_N_SXX:  begin ld_a = W'(ld_job.sxx); ld_b = BW'(ld_job.n);  end
            OP_SX_SX:  begin ld_a = W'(ld_job.sx);  ld_b = BW'(ld_job.sx); end
            OP_N_SXY:  begin ld_a = W'(ld_job.sxy); ld_b = BW'(ld_job.n);  end
            OP_SX_SY:  begin ld_a = W'(ld_job.sx);  ld_b = BW'(ld_job.sy); end
            OP_SX_SXY: begin ld_a = W'(ld_job.sxy); ld_b = BW'(ld_job.sx); end
            OP_SY_SXX: begin ld_a = W'(ld_job.sxx); ld_b = BW'(ld_job.sy); end
            default:   begin ld_a = '0;             ld_b = '0;             end
        endcase
    end

    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign sub     = tmp_reg - acc_sum;
    assign lt      = tmp_reg < acc_sum;
    assign mag     = lt ? (acc_sum - tmp_reg) : sub;

    assign shifted = {rem_reg[MW-1:0], dq_reg[DW-1]};
    assign ge      = shifted >= {1'b0, num_mag_reg};

    // Round half away from zero on magnitudes, then clamp to the signed 32-bit range.
    assign rnd = {rem_reg, 1'b0} >= {2'b00, num_mag_reg};
    assign neg = div_sel_reg ? (diff_neg_reg ^ num_neg_reg) : num_neg_reg;
    assign q   = {1'b0, dq_reg} + (DW+1)'(rnd);
    assign lim = neg ? (DW+1)'(33'h0_8000_0000) : (DW+1)'(33'h0_7FFF_FFFF);
    assign v   = (q > lim) ? lim : q;
    assign val = neg ? (32'd0 - v[31:0]) : v[31:0];

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        job_next      = job_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        den_next      = den_reg;
        num_mag_next  = num_mag_reg;
        num_neg_next  = num_neg_reg;
        diff_next     = diff_reg;
        diff_neg_next = diff_neg_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        div_sel_next  = div_sel_reg;
        gain_next     = gain_reg;
        result_next   = result_reg;
        job_pop       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    job_next    = job;
                    op_next     = OP_N_SXX;
                    mcand_next  = ld_a;
                    mplier_next = ld_b;
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[BW-1:1]};
                cnt_next    = cnt_reg + 7'd1;
                if (cnt_reg == 7'(BW-1))
                begin
                    case (op_reg)
                        OP_SX_SX:
                        begin
                            den_next = sub[MW-1:0];
                        end
                        OP_SX_SY:
                        begin
                            num_neg_next = lt;
                            num_mag_next = mag[MW-1:0];
                        end
                        OP_SY_SXX:
                        begin
                            diff_neg_next = lt;
                            diff_next     = mag;
                        end
                        default:
                        begin
                            tmp_next = acc_sum;
                        end
                    endcase
                    if (op_reg == OP_SY_SXX)
                    begin
                        // Spread and slope are already final here.
                        if (job_reg.ovf)
                        begin
                            result_next = '{gain: '0, offset: '0,
                                            fit_status: lcf_pkg::FIT_TOO_MANY};
                            state_next  = ST_DONE;
                        end
                        else if (den_reg == '0)
                        begin
                            result_next = '{gain: '0, offset: '0,
                                            fit_status: lcf_pkg::FIT_NO_SPREAD};
                            state_next  = ST_DONE;
                        end
                        else if (num_mag_reg == '0)
                        begin
                            result_next = '{gain: '0, offset: '0,
                                            fit_status: lcf_pkg::FIT_NO_SLOPE};
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            dq_next      = {den_reg, 24'd0};
                            rem_next     = '0;
                            cnt_next     = '0;
                            div_sel_next = 1'b0;
                            state_next   = ST_DIV;
                        end
                    end
                    else
                    begin
                        op_next     = ld_op;
                        mcand_next  = ld_a;
                        mplier_next = ld_b;
                        acc_next    = '0;
                        cnt_next    = '0;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? (shifted - {1'b0, num_mag_reg}) : shifted;
                dq_next  = {dq_reg[DW-2:0], ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DW-1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (!div_sel_reg)
                begin
                    gain_next    = val;
                    dq_next      = {diff_reg, 8'd0};
                    rem_next     = '0;
                    cnt_next     = '0;
                    div_sel_next = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    result_next = '{gain: gain_reg, offset: val,
                                    fit_status: lcf_pkg::FIT_OK};
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign empty  = (state_reg != ST_DONE);
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cnt_reg      <= cnt_next;
        job_reg      <= job_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        acc_reg      <= acc_next;
        tmp_reg      <= tmp_next;
        den_reg      <= den_next;
        num_mag_reg  <= num_mag_next;
        num_neg_reg  <= num_neg_next;
        diff_reg     <= diff_next;
        diff_neg_reg <= diff_neg_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_sel_reg  <= div_sel_next;
        gain_reg     <= gain_next;
        result_reg   <= result_next;
    end

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && result_reg.fit_status != lcf_pkg::FIT_OK)
        |-> (result_reg.gain == '0 && result_reg.offset == '0))
        else $error("error result carries nonzero gain or offset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !pop) |=> (state_reg == ST_DONE && $stable(result_reg)))
        else $error("waiting result changed before it was taken");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (num_mag_reg != '0))
        else $error("divider running with a zero divisor");
`endif

endmodule

/* sim/linear_calibration_fit_core_test.sv */
// Self-checking testbench for the linear calibration fit core.
`timescale 1ns / 1ps
module linear_calibration_fit_core_test;

    localparam int MAX_PTS = 128;
    localparam int HOLD_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        lcf_pkg::sample_t beat;
        bit               wait_drain;
    } feed_t;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    lcf_pkg::sample_t sample;
    logic             empty;
    logic             pop;
    lcf_pkg::result_t result;

    feed_t            feed_q[$];
    lcf_pkg::result_t fit_q[$];

    // Running sums of the set being collected, as the block should hold them.
    int unsigned  acc_n;
    logic [127:0] acc_x, acc_y, acc_xy, acc_xx;
    bit           acc_ovf;

    int  errors = 0;
    int  beats_in = 0;
    int  fits_out = 0;
    int  status_seen[4] = '{default: 0};
    int  total_beats = 0;
    int  idle_cycles = 0;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_count;
    bit  hold_done;
    bit  stim_done = 0;
    bit  in_fire = 0;

    linear_calibration_fit_core #(.MAX_POINTS(MAX_PTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .sample(sample),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [127:0] round_div(input logic [127:0] num, input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        q = num / d;
        r = num % d;
        if (r >= d - r)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [31:0] clamp32(input logic [127:0] mag, input bit neg);
        logic [127:0] lim;
        logic [31:0]  v;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v = (mag > lim) ? lim[31:0] : mag[31:0];
        return neg ? -v : v;
    endfunction

    function automatic void clear_sums();
        acc_n = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        acc_ovf = 0;
    endfunction

    // Folds one accepted beat into the sums and, on a last beat, queues the fit.
    function automatic void fold_point(input lcf_pkg::sample_t s);
        logic [127:0]     n, den, pa, pb, num, p, q, diff;
        bit               num_neg, diff_neg;
        lcf_pkg::result_t r;
        if (acc_n >= MAX_PTS)
            acc_ovf = 1;
        else
        begin
            acc_n++;
            acc_x += s.set_point;
            acc_y += s.measured;
            acc_xy += 128'(s.set_point) * s.measured;
            acc_xx += 128'(s.set_point) * s.set_point;
        end
        if (!s.last)
            return;
        n = acc_n;
        den = n * acc_xx - acc_x * acc_x;
        pa = n * acc_xy;
        pb = acc_x * acc_y;
        num_neg = pa < pb;
        num = num_neg ? pb - pa : pa - pb;
        r.gain = '0;
        r.offset = '0;
        if (acc_ovf)
            r.fit_status = lcf_pkg::FIT_TOO_MANY;
        else if (den == 0)
            r.fit_status = lcf_pkg::FIT_NO_SPREAD;
        else if (num == 0)
            r.fit_status = lcf_pkg::FIT_NO_SLOPE;
        else
        begin
            r.fit_status = lcf_pkg::FIT_OK;
            p = acc_x * acc_xy;
            q = acc_y * acc_xx;
            diff_neg = p < q;
            diff = diff_neg ? q - p : p - q;
            r.gain = clamp32(round_div(den << 24, num), num_neg);
            r.offset = clamp32(round_div(diff << 8, num), diff_neg != num_neg);
        end
        fit_q.push_back(r);
        clear_sums();
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_beat(input logic [15:0] x, input logic [15:0] y, input bit lst);
        feed_t f;
        f.beat.set_point = x;
        f.beat.measured = y;
        f.beat.last = lst;
        f.wait_drain = 0;
        feed_q.push_back(f);
        total_beats++;
    endfunction

    function automatic void add_drain();
        feed_t f;
        f.beat = '0;
        f.wait_drain = 1;
        feed_q.push_back(f);
    endfunction

    // One calibration set: mostly a noisy line, sometimes pure noise.
    function automatic void add_set(input int pts);
        int gain_num, ofs, x, y;
        bit noisy;
        gain_num = $urandom_range(1, 400) - 200;
        ofs = $urandom_range(0, 65535);
        noisy = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pts; i++)
        begin
            x = $urandom_range(0, 65535);
            y = noisy ? pick16() : ofs + (x * gain_num) / 100 + $urandom_range(0, 64) - 32;
            if (y < 0)
                y = 0;
            if (y > 65535)
                y = 65535;
            add_beat(noisy ? pick16() : 16'(x), 16'(y), i == pts - 1);
        end
    endfunction

    // Stimulus plan.
    initial
    begin
        // Single point and repeated set point: no spread.
        add_beat(16'h1234, 16'h4321, 1);
        add_beat(16'd500, 16'd10, 0);
        add_beat(16'd500, 16'd900, 1);
        // Flat response: zero slope.
        add_beat(16'd0, 16'd777, 0);
        add_beat(16'hFFFF, 16'd777, 1);
        // Field extremes, rising and falling lines.
        add_beat(16'd0, 16'd0, 0);
        add_beat(16'hFFFF, 16'hFFFF, 1);
        add_beat(16'd0, 16'hFFFF, 0);
        add_beat(16'hFFFF, 16'd0, 1);
        // Very steep and very shallow lines; the shallow one pushes both outputs to their limits.
        add_beat(16'd0, 16'd0, 0);
        add_beat(16'd1, 16'hFFFF, 1);
        add_beat(16'd0, 16'hFFFF, 0);
        add_beat(16'hFFFF, 16'hFFFE, 1);
        add_beat(16'd100, 16'd3, 0);
        add_beat(16'd200, 16'd5, 0);
        add_beat(16'd300, 16'd4, 1);
        add_drain();
        // Exactly the point limit, then two points too many.
        add_set(MAX_PTS);
        add_set(MAX_PTS + 2);
        add_drain();
        while (total_beats < 500)
        begin
            add_set($urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 8));
            if ($urandom_range(0, 30) == 0)
                add_drain();
        end
        stim_done = 1;
    end

    // Driver: inputs change on the falling edge.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            sample <= '0;
        end
        else if (push && !in_fire)
        begin
            // An offered beat stays unchanged until it is taken.
            push <= 1'b1;
        end
        else if (feed_q.size() > 0 && feed_q[0].wait_drain)
        begin
            push <= 1'b0;
            if (fit_q.size() == 0)
                void'(feed_q.pop_front());
        end
        else if (feed_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
        begin
            push <= 1'b1;
            sample <= feed_q[0].beat;
        end
        else
            push <= 1'b0;
    end

    // Receiver ready, with one long hold-off in the last third of the run.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_count <= 0;
            hold_done <= 0;
        end
        else if (hold_count > 0)
        begin
            pop <= 1'b0;
            hold_count <= hold_count - 1;
        end
        else if (!hold_done && beats_in > 360)
        begin
            pop <= 1'b0;
            hold_count <= HOLD_CYCLES;
            hold_done <= 1;
        end
        else
            pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always_comb
    begin
        if (beats_in < 170)
        begin
            sender_idle_pct = 22;
            receiver_idle_pct = 72;
        end
        else if (beats_in < 340)
        begin
            sender_idle_pct = 72;
            receiver_idle_pct = 22;
        end
        else
        begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
    end

    // Acceptance, prediction, checking and stall watchdog on the rising edge.
    always @(posedge clk)
    begin
        in_fire <= rst_n && push && !full;
        if (rst_n)
        begin
            if (push && !full)
            begin
                fold_point(sample);
                void'(feed_q.pop_front());
                beats_in <= beats_in + 1;
            end
            if (pop && !empty)
            begin
                if (fit_q.size() == 0)
                begin
                    $error("result beat with no fit pending");
                    errors++;
                end
                else
                begin
                    if (result.gain !== fit_q[0].gain)
                    begin
                        $error("gain expected %0d actual %0d", fit_q[0].gain, result.gain);
                        errors++;
                    end
                    if (result.offset !== fit_q[0].offset)
                    begin
                        $error("offset expected %0d actual %0d", fit_q[0].offset,
                               result.offset);
                        errors++;
                    end
                    if (result.fit_status !== fit_q[0].fit_status)
                    begin
                        $error("fit_status expected %0d actual %0d", fit_q[0].fit_status,
                               result.fit_status);
                        errors++;
                    end
                    status_seen[fit_q[0].fit_status]++;
                    void'(fit_q.pop_front());
                end
                fits_out <= fits_out + 1;
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clear_sums();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && feed_q.size() == 0 && fit_q.size() == 0);
        repeat (400) @(posedge clk);
        $display("%0d sample beats, %0d fits checked (ok %0d, no spread %0d, no slope %0d,",
                 beats_in, fits_out, status_seen[0], status_seen[1], status_seen[2]);
        $display("too many points %0d), under random stalls and a long result back-pressure",
                 status_seen[3]);
        if (errors == 0 && fit_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
